@@ rtl/dcm_pkg.sv @@
`timescale 1ns / 1ps
package dcm_pkg;

  // Input item kinds (carried on tuser)
  localparam logic ACT_SYMBOL = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // Symbol codes
  localparam logic [2:0] SYM_A = 3'd0;
  localparam logic [2:0] SYM_C = 3'd1;
  localparam logic [2:0] SYM_N = 3'd2;
  localparam logic [2:0] SYM_G = 3'd3;
  localparam logic [2:0] SYM_T = 3'd4;
  localparam logic [2:0] SYM_MAX = 3'd4;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_DEPTH = 2'd0;
  localparam logic [1:0] CFG_ALPHA = 2'd1;
  localparam logic [1:0] CFG_IR    = 2'd2;

  // Counter row layout: five symbol lanes then the context total
  localparam int ROW_LANES  = 6;
  localparam int LANE_TOTAL = 5;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       action;
    logic [2:0] sym;
  } req_t;

  typedef struct packed {
    logic [2:0]  depth;
    logic [15:0] alpha;
    logic        ir;
  } cfg_t;

  function automatic logic [2:0] map_char(input logic [7:0] ch);
    logic [2:0] s;
    case (ch)
      8'h41:   s = SYM_A;
      8'h43:   s = SYM_C;
      8'h47:   s = SYM_G;
      8'h54:   s = SYM_T;
      default: s = SYM_N;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/dna_context_model_counter.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Contents
// s_axis    in         tdata: symbol_char; tuser: action (clear when high)
// m_axis    out        tdata: code, count, total, numerator, denominator
// cfg       in         cfg_index selects the register, cfg_data is written
//
// A symbol is taken from the queue, then makes the direct counter row update
// alone with inverted repeats off, or the direct, reverse and total updates
// with them on, and then loads the result; each counter row update is a read
// then a write on the counter memory. After reset and after each clear the
// memory is swept one row a cycle, all 5**MAX_DEPTH rows (15625 by default),
// with s_axis_tready low. A two-entry request queue lets the input side keep
// taking requests while the result register is stalled.
module dna_context_model_counter #(
  parameter int MAX_DEPTH  = 6,
  parameter int COUNT_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] symbol_char
  input  logic          s_axis_tuser,   // [0] action
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [2:0] symbol_code, [34:3] symbol_count, [66:35] context_total,
  // [114:67] prob_numerator, [162:115] prob_denominator, [167:163] zero
  output logic [167:0]  m_axis_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  dcm_pkg::cfg_t cfg;
  dcm_pkg::req_t push_req;
  dcm_pkg::req_t q_head;
  logic          push;
  logic          q_pop;
  logic          q_empty;
  logic          q_full;
  logic [1:0]    q_fill;
  logic          sweeping;
  logic [2:0]    out_code;
  logic [31:0]   out_count;
  logic [31:0]   out_total;
  logic [47:0]   out_num;
  logic [47:0]   out_den;

  assign cfg_ready = 1'b1;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth <= 3'd4;
      cfg.alpha <= 16'd1;
      cfg.ir    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dcm_pkg::CFG_DEPTH: cfg.depth <= cfg_data[2:0];
        dcm_pkg::CFG_ALPHA: cfg.alpha <= cfg_data;
        dcm_pkg::CFG_IR:    cfg.ir    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dcm_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .sweeping      (sweeping),
    .push          (push),
    .push_req      (push_req)
  );

  dcm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full),
    .fill     (q_fill)
  );

  dcm_back #(
    .MAX_DEPTH  (MAX_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .sweeping  (sweeping),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .out_code  (out_code),
    .out_count (out_count),
    .out_total (out_total),
    .out_num   (out_num),
    .out_den   (out_den)
  );

  assign m_axis_tdata = {5'd0, out_den, out_num, out_total, out_count, out_code};

  // Never take a request during a table sweep
  assert property (@(posedge clk) disable iff (rst) sweeping |-> !s_axis_tready)
    else $error("request accepted during table sweep");

  // Queue fill stays within its depth
  assert property (@(posedge clk) disable iff (rst) q_fill <= 2'(dcm_pkg::QUEUE_DEPTH))
    else $error("request queue overfilled");

  // No pop from an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("pop from empty request queue");

  // Results carry a legal symbol code
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[2:0] <= dcm_pkg::SYM_MAX))
    else $error("illegal symbol code in result");

endmodule

@@ rtl/dcm_front.sv @@
`timescale 1ns / 1ps
module dcm_front (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  input  logic              s_axis_tuser,
  input  logic              q_full,
  input  logic              sweeping,
  output logic              push,
  output dcm_pkg::req_t     push_req
);

  // Take a request whenever the queue has room and the table is usable
  assign s_axis_tready = !q_full && !sweeping;
  assign push          = s_axis_tvalid && s_axis_tready;

  // Classify the character into its symbol code
  always_comb begin
    push_req.action = s_axis_tuser;
    push_req.sym    = dcm_pkg::map_char(s_axis_tdata);
  end

endmodule

@@ rtl/dcm_queue.sv @@
`timescale 1ns / 1ps
module dcm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dcm_pkg::req_t push_req,
  input  logic          pop,
  output dcm_pkg::req_t head,
  output logic          empty,
  output logic          full,
  output logic [1:0]    fill
);

  dcm_pkg::req_t slots [dcm_pkg::QUEUE_DEPTH];
  logic          wr_ptr;
  logic          rd_ptr;

  assign empty = (fill == 2'd0);
  assign full  = (fill == 2'(dcm_pkg::QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

@@ rtl/dcm_back.sv @@
`timescale 1ns / 1ps
module dcm_back #(
  parameter int MAX_DEPTH  = 6,
  parameter int COUNT_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  dcm_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  dcm_pkg::req_t q_head,
  output logic          q_pop,
  output logic          sweeping,
  output logic          m_valid,
  input  logic          m_ready,
  output logic [2:0]    out_code,
  output logic [31:0]   out_count,
  output logic [31:0]   out_total,
  output logic [47:0]   out_num,
  output logic [47:0]   out_den
);

  localparam int ROWS = 5 ** MAX_DEPTH;
  localparam int RB   = $clog2(ROWS);
  localparam int DB   = $clog2(MAX_DEPTH + 1);
  localparam int RST_DEPTH = (MAX_DEPTH < 4) ? MAX_DEPTH : 4;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_WR   = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [1:0] STEP_DIR = 2'd0;
  localparam logic [1:0] STEP_REV = 2'd1;
  localparam logic [1:0] STEP_TOT = 2'd2;

  typedef logic [MAX_DEPTH-1:0][2:0] digits_t;
  typedef logic [dcm_pkg::ROW_LANES-1:0][COUNT_BITS-1:0] row_t;

  // Base-5 context digits to row number
  function automatic logic [RB-1:0] to_row(input digits_t d);
    logic [RB+3:0] acc;
    logic [RB+3:0] p;
    acc = '0;
    p   = (RB+4)'(1);
    for (int i = 0; i < MAX_DEPTH; i++) begin
      acc = acc + (RB+4)'(d[i]) * p;
      p   = p * (RB+4)'(5);
    end
    return acc[RB-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] x);
    return (&x) ? x : x + COUNT_BITS'(1);
  endfunction

  function automatic logic [31:0] to32(input logic [COUNT_BITS-1:0] x);
    logic [63:0] t;
    t = 64'(x);
    return t[31:0];
  endfunction

  logic [2:0]     state;
  logic [1:0]     step;
  logic [RB-1:0]  clr_addr;
  digits_t        direct;
  digits_t        reverse;
  digits_t        ctx;
  logic [2:0]     sym;
  logic [2:0]     rsym;
  logic [COUNT_BITS-1:0] n;
  logic [COUNT_BITS-1:0] total;
  row_t           mem [ROWS];
  row_t           rd_data;

  logic [DB-1:0]  depth;
  digits_t        ctx_m;
  digits_t        rev_m;
  digits_t        rev_next;
  digits_t        dir_next;
  digits_t        rev_clear;
  logic [RB-1:0]  cur_addr;
  logic           mem_we;
  logic [RB-1:0]  mem_wa;
  row_t           mem_wd;

  // Clamp the configured depth to 1..MAX_DEPTH
  always_comb begin
    if (cfg.depth == 3'd0) begin
      depth = DB'(1);
    end else if (32'(cfg.depth) > MAX_DEPTH) begin
      depth = DB'(MAX_DEPTH);
    end else begin
      depth = DB'(cfg.depth);
    end
  end

  // Reduce contexts to the active depth and form their successors
  always_comb begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      ctx_m[i]     = (i < 32'(depth)) ? direct[i]  : 3'd0;
      rev_m[i]     = (i < 32'(depth)) ? reverse[i] : 3'd0;
      rev_clear[i] = (i < 32'(depth)) ? dcm_pkg::SYM_MAX : 3'd0;
    end
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (i == 0) begin
        dir_next[i] = q_head.sym;
      end else if (i < 32'(depth)) begin
        dir_next[i] = ctx_m[i-1];
      end else begin
        dir_next[i] = 3'd0;
      end
      if (i + 1 < 32'(depth)) begin
        rev_next[i] = rev_m[i+1];
      end else if (i + 1 == 32'(depth)) begin
        rev_next[i] = dcm_pkg::SYM_MAX - q_head.sym;
      end else begin
        rev_next[i] = 3'd0;
      end
    end
  end

  assign cur_addr = (step == STEP_REV) ? to_row(reverse) : to_row(ctx);
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign sweeping = (state == ST_INIT);

  // Apply the counter increments of the current step, or zero the row during a sweep
  always_comb begin
    mem_wd = rd_data;
    case (step)
      STEP_DIR: begin
        mem_wd[sym] = sat_inc(rd_data[sym]);
        if (!cfg.ir) begin
          mem_wd[dcm_pkg::LANE_TOTAL] = sat_inc(rd_data[dcm_pkg::LANE_TOTAL]);
        end
      end
      STEP_REV: begin
        mem_wd[rsym] = sat_inc(rd_data[rsym]);
        mem_wd[dcm_pkg::LANE_TOTAL] = sat_inc(rd_data[dcm_pkg::LANE_TOTAL]);
      end
      default: begin
        mem_wd[dcm_pkg::LANE_TOTAL] = sat_inc(rd_data[dcm_pkg::LANE_TOTAL]);
      end
    endcase
    if (state == ST_INIT) begin
      mem_wd = '0;
    end
  end

  assign mem_we = (state == ST_INIT) || (state == ST_WR);
  assign mem_wa = (state == ST_INIT) ? clr_addr : cur_addr;

  // Counter memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[cur_addr];
  end

  // Sequence clears and read-modify-write steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      clr_addr <= '0;
      direct   <= '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
        reverse[i] <= (i < RST_DEPTH) ? dcm_pkg::SYM_MAX : 3'd0;
      end
      m_valid  <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one loads this cycle
      if (m_valid && m_ready && state != ST_DONE) begin
        m_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          if (clr_addr == RB'(ROWS - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + RB'(1);
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_head.action == dcm_pkg::ACT_CLEAR) begin
              direct   <= '0;
              reverse  <= rev_clear;
              clr_addr <= '0;
              state    <= ST_INIT;
            end else begin
              ctx    <= ctx_m;
              sym    <= q_head.sym;
              rsym   <= rev_m[0];
              direct <= dir_next;
              if (cfg.ir) begin
                reverse <= rev_next;
              end
              step  <= STEP_DIR;
              state <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state <= ST_WR;
        end
        ST_WR: begin
          case (step)
            STEP_DIR: begin
              n <= rd_data[sym];
              if (cfg.ir) begin
                step  <= STEP_REV;
                state <= ST_RD;
              end else begin
                total <= mem_wd[dcm_pkg::LANE_TOTAL];
                state <= ST_DONE;
              end
            end
            STEP_REV: begin
              step  <= STEP_TOT;
              state <= ST_RD;
            end
            default: begin
              total <= mem_wd[dcm_pkg::LANE_TOTAL];
              state <= ST_DONE;
            end
          endcase
        end
        ST_DONE: begin
          if (!m_valid || m_ready) begin
            m_valid <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Load the result register with the estimator terms
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_valid || m_ready)) begin
      out_code  <= sym;
      out_count <= to32(n);
      out_total <= to32(total);
      out_num   <= 48'(cfg.alpha) * 48'(to32(n)) + 48'd1;
      out_den   <= 48'(cfg.alpha) * 48'(to32(total)) + 48'd5;
    end
  end

endmodule
